// File: sv/lssc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and register defaults for the line search sweep controller.
// No dependencies; used by every module of the block.
package lssc_pkg;

   // Request kinds carried in req_tuser
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;

   // Sweep direction
   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;

   // Motor commands
   localparam logic [1:0] MC_NONE  = 2'd0;
   localparam logic [1:0] MC_STOP  = 2'd1;
   localparam logic [1:0] MC_RIGHT = 2'd2;
   localparam logic [1:0] MC_LEFT  = 2'd3;

   // Sound commands
   localparam logic [1:0] SND_NONE  = 2'd0;
   localparam logic [1:0] SND_FOUND = 2'd1;
   localparam logic [1:0] SND_FAIL  = 2'd2;
   localparam logic [1:0] SND_START = 2'd3;

   // Outcome codes
   localparam logic [2:0] OUT_NONE      = 3'd0;
   localparam logic [2:0] OUT_FOUND     = 3'd1;
   localparam logic [2:0] OUT_EXHAUSTED = 3'd2;
   localparam logic [2:0] OUT_CANCELLED = 3'd3;
   localparam logic [2:0] OUT_STOPPED   = 3'd4;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_ROTATE_SPEED    = 3'd0;
   localparam logic [2:0] CSR_CATCH_WINDOW    = 3'd1;
   localparam logic [2:0] CSR_MAX_PHASES      = 3'd2;
   localparam logic [2:0] CSR_PHASE_STEP      = 3'd3;
   localparam logic [2:0] CSR_FOLLOW_IF_FOUND = 3'd4;
   localparam logic [2:0] CSR_BLINK_PERIOD    = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   // Register reset values
   localparam logic [7:0]  RST_ROTATE_SPEED    = 8'd80;
   localparam logic [3:0]  RST_CATCH_WINDOW    = 4'd4;
   localparam logic [3:0]  RST_MAX_PHASES      = 4'd8;
   localparam logic [13:0] RST_PHASE_STEP      = 14'd100;
   localparam logic        RST_FOLLOW_IF_FOUND = 1'b1;
   localparam logic [7:0]  RST_BLINK_PERIOD    = 8'd25;

   localparam logic [3:0] SIGHT_MAX = 4'd15;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   typedef struct packed {
      logic [7:0]  rotate_speed;
      logic [3:0]  catch_window;
      logic [3:0]  max_phases;
      logic [13:0] phase_step;
      logic        follow_if_found;
      logic [7:0]  blink_period;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       follow_active;
      logic       line_lost;
      logic       deviation_positive;
   } item_type;

   typedef struct packed {
      logic [1:0] motor_cmd;
      logic [7:0] motor_speed;
      logic       led_on;
      logic [1:0] sound_cmd;
      logic       enable_follow;
      logic       active;
      logic [2:0] outcome;
   } rsp_type;

   typedef struct packed {
      logic        enabled;
      logic [1:0]  direction;
      logic [14:0] tick_count;
      logic [14:0] sweep_end;
      logic [3:0]  sweep_number;
      logic [3:0]  sighting_count;
      logic [7:0]  blink_count;
      logic        led_level;
   } state_type;

endpackage

// File: sv/line_search_sweep_controller_unit.sv
`timescale 1ns / 1ps
// A request accepted into the input register moves to the result register and is offered
// on rsp_tvalid from there. Throughput: one request per cycle while rsp_tready is high;
// the step logic between the two registers sets this figure.
// A response held by rsp_tready low keeps the next request in the input register (not stepped).
// Reset (synchronous, active high): search idle, LED off, registers at their defaults.
// Top level of the line search sweep controller; uses lssc_pkg, lssc_csr and lssc_core.
module line_search_sweep_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lssc_pkg::REQ_TDATA_W-1:0]    req_tdata,  // follow_active, line_lost,
                                                           // deviation_positive, zero pad
   input  logic [1:0]                          req_tuser,  // req_type
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lssc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // motor_cmd[1:0], motor_speed[9:2],
                                                           // led_on[10], sound_cmd[12:11],
                                                           // enable_follow[13], active[14],
                                                           // outcome[17:15], zero pad
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lssc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lssc_pkg::CSR_DATA_W-1:0]     csr_data
);

   lssc_pkg::cfg_type  cfg;
   lssc_pkg::item_type item_ff, item_in;
   lssc_pkg::rsp_type  rsp_ff, step_rsp;
   logic               in_valid_ff, in_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic               advance;

   assign csr_ready = 1'b1;

   lssc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Input stage moves to the result register when that one is free or drains
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      item_in.req_type           = req_tuser;
      item_in.follow_active      = req_tdata[0];
      item_in.line_lost          = req_tdata[1];
      item_in.deviation_positive = req_tdata[2];
      in_valid_in  = (req_tvalid & req_tready) | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & ~rsp_tready);
   end

   lssc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // Handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.outcome, rsp_ff.active, rsp_ff.enable_follow,
                        rsp_ff.sound_cmd, rsp_ff.led_on, rsp_ff.motor_speed,
                        rsp_ff.motor_cmd};

endmodule

// File: sv/lssc_csr.sv
`timescale 1ns / 1ps
// Configuration register file of the line search sweep controller.
// Depends on lssc_pkg.
module lssc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [lssc_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [lssc_pkg::CSR_DATA_W-1:0]  wr_data,
   output lssc_pkg::cfg_type                cfg
);

   lssc_pkg::cfg_type cfg_ff, cfg_in;

   // Decode one register write per transfer; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            lssc_pkg::CSR_ROTATE_SPEED:    cfg_in.rotate_speed    = wr_data[7:0];
            lssc_pkg::CSR_CATCH_WINDOW:    cfg_in.catch_window    = wr_data[3:0];
            lssc_pkg::CSR_MAX_PHASES:      cfg_in.max_phases      = wr_data[3:0];
            lssc_pkg::CSR_PHASE_STEP:      cfg_in.phase_step      = wr_data[13:0];
            lssc_pkg::CSR_FOLLOW_IF_FOUND: cfg_in.follow_if_found = wr_data[0];
            lssc_pkg::CSR_BLINK_PERIOD:    cfg_in.blink_period    = wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotate_speed    <= lssc_pkg::RST_ROTATE_SPEED;
         cfg_ff.catch_window    <= lssc_pkg::RST_CATCH_WINDOW;
         cfg_ff.max_phases      <= lssc_pkg::RST_MAX_PHASES;
         cfg_ff.phase_step      <= lssc_pkg::RST_PHASE_STEP;
         cfg_ff.follow_if_found <= lssc_pkg::RST_FOLLOW_IF_FOUND;
         cfg_ff.blink_period    <= lssc_pkg::RST_BLINK_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/lssc_core.sv
`timescale 1ns / 1ps
// Search state and single-pass step logic of the line search sweep controller.
// Depends on lssc_pkg.
module lssc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  lssc_pkg::item_type item,
   input  lssc_pkg::cfg_type  cfg,
   output lssc_pkg::rsp_type  rsp
);

   lssc_pkg::state_type state_ff, state_in;

   // One step of the search for the item in the input register
   always_comb begin
      state_in          = state_ff;
      rsp.motor_cmd     = lssc_pkg::MC_NONE;
      rsp.motor_speed   = '0;
      rsp.sound_cmd     = lssc_pkg::SND_NONE;
      rsp.enable_follow = 1'b0;
      rsp.outcome       = lssc_pkg::OUT_NONE;

      case (item.req_type)
         lssc_pkg::REQ_START: begin
            if (!state_ff.enabled) begin
               rsp.sound_cmd      = lssc_pkg::SND_START;
               rsp.motor_cmd      = lssc_pkg::MC_STOP;
               state_in.direction = lssc_pkg::DIR_NONE;
               state_in.enabled   = 1'b1;
            end
         end
         lssc_pkg::REQ_STOP: begin
            state_in.led_level = 1'b0;
            if (state_ff.enabled) begin
               rsp.sound_cmd      = lssc_pkg::SND_FAIL;
               rsp.motor_cmd      = lssc_pkg::MC_STOP;
               rsp.outcome        = lssc_pkg::OUT_STOPPED;
               state_in.direction = lssc_pkg::DIR_NONE;
               state_in.enabled   = 1'b0;
            end
         end
         lssc_pkg::REQ_TICK: begin
            if (state_ff.enabled) begin
               if (item.follow_active) begin
                  // following took over: cancel quietly
                  state_in.led_level = 1'b0;
                  state_in.direction = lssc_pkg::DIR_NONE;
                  state_in.enabled   = 1'b0;
                  rsp.outcome        = lssc_pkg::OUT_CANCELLED;
               end else if (state_ff.direction == lssc_pkg::DIR_NONE) begin
                  // first tick only sets up the first sweep
                  state_in.tick_count     = '0;
                  state_in.sweep_number   = '0;
                  state_in.sweep_end      = {1'b0, cfg.phase_step};
                  state_in.sighting_count = '0;
                  state_in.blink_count    = '0;
                  state_in.direction      = item.deviation_positive ?
                                            lssc_pkg::DIR_LEFT : lssc_pkg::DIR_RIGHT;
               end else begin
                  if (item.line_lost) begin
                     state_in.sighting_count = '0;
                     state_in.tick_count     = state_ff.tick_count + 15'd1;
                     if (state_in.tick_count >= state_ff.sweep_end) begin
                        rsp.motor_cmd         = lssc_pkg::MC_STOP;
                        state_in.sweep_number = state_ff.sweep_number + 4'd1;
                        if (state_in.sweep_number >= cfg.max_phases) begin
                           rsp.sound_cmd      = lssc_pkg::SND_FAIL;
                           rsp.outcome        = lssc_pkg::OUT_EXHAUSTED;
                           state_in.led_level = 1'b1;
                           state_in.direction = lssc_pkg::DIR_NONE;
                           state_in.enabled   = 1'b0;
                        end else begin
                           // reverse; later sweeps are twice as long
                           state_in.direction  = (state_ff.direction == lssc_pkg::DIR_LEFT) ?
                                                 lssc_pkg::DIR_RIGHT : lssc_pkg::DIR_LEFT;
                           state_in.tick_count = '0;
                           state_in.sweep_end  = {cfg.phase_step, 1'b0};
                        end
                     end else begin
                        rsp.motor_cmd   = (state_ff.direction == lssc_pkg::DIR_LEFT) ?
                                          lssc_pkg::MC_LEFT : lssc_pkg::MC_RIGHT;
                        rsp.motor_speed = cfg.rotate_speed;
                     end
                  end else begin
                     if (state_ff.sighting_count < lssc_pkg::SIGHT_MAX) begin
                        state_in.sighting_count = state_ff.sighting_count + 4'd1;
                     end
                     if (state_in.sighting_count >= cfg.catch_window) begin
                        rsp.motor_cmd      = lssc_pkg::MC_STOP;
                        rsp.sound_cmd      = lssc_pkg::SND_FOUND;
                        rsp.outcome        = lssc_pkg::OUT_FOUND;
                        rsp.enable_follow  = cfg.follow_if_found;
                        state_in.led_level = 1'b0;
                        state_in.direction = lssc_pkg::DIR_NONE;
                        state_in.enabled   = 1'b0;
                     end
                  end
                  // LED blink runs on every counted tick, the ending one too
                  state_in.blink_count = state_ff.blink_count + 8'd1;
                  if (state_in.blink_count >= cfg.blink_period) begin
                     state_in.led_level   = ~state_in.led_level;
                     state_in.blink_count = '0;
                  end
               end
            end
         end
         default: ;
      endcase

      rsp.led_on = state_in.led_level;
      rsp.active = state_in.enabled;
   end

   // Search state advances once per item moved to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // An idle search never holds a sweep direction
   a_idle_no_dir: assert property (@(posedge clock) disable iff (reset)
      !state_ff.enabled |-> state_ff.direction == lssc_pkg::DIR_NONE)
      else $error("direction held while search disabled");

   // Any reported outcome ends the search
   a_outcome_ends: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.outcome != lssc_pkg::OUT_NONE |-> !rsp.active)
      else $error("outcome reported with search still active");

   // The active flag reported matches the state committed
   a_active_commit: assert property (@(posedge clock) disable iff (reset)
      step_en |=> state_ff.enabled == $past(rsp.active))
      else $error("active flag disagrees with committed state");

   // Rotation only happens with a sweep direction set
   a_rotate_dir: assert property (@(posedge clock) disable iff (reset)
      step_en && (rsp.motor_cmd == lssc_pkg::MC_LEFT || rsp.motor_cmd == lssc_pkg::MC_RIGHT)
      |-> state_ff.direction != lssc_pkg::DIR_NONE)
      else $error("rotate command without sweep direction");
`endif

endmodule
